// File: sv/lyn_pkg.sv
// ----------------------------------------------------------------------------
// lyn_pkg
// Shared sizes, types and codes of the two-order Lyndon array engine.
// ----------------------------------------------------------------------------
package lyn_pkg;

  // String capacity and alphabet
  localparam int MAX_LEN     = 64;
  localparam int SYMBOL_BITS = 8;

  // Widths of the item fields
  localparam int IN_SYM_W   = 8;
  localparam int POS_W      = 6;
  localparam int LEN_W      = 7;
  localparam int OUT_DATA_W = 24;

  // Stored symbol width: only the low SYMBOL_BITS of a symbol count
  localparam int SYM_W  = (SYMBOL_BITS < IN_SYM_W) ? SYMBOL_BITS : IN_SYM_W;
  // Address of one string position, and a count that can hold MAX_LEN
  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int CNT_W  = $clog2(MAX_LEN + 1);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,   // store symbols until the last one
    ST_INIT,   // start a new position i
    ST_LREQ,   // read len[j]
    ST_LDAT,   // capture len[j]
    ST_CREQ,   // read s[i+k] and s[j+k]
    ST_CDAT,   // compare the two symbols
    ST_WRITE,  // write len[i]
    ST_OREQ,   // read both lengths of one position
    ST_OLOAD   // hand the result to the output register
  } state_t;

  // Symbol order
  typedef enum logic {
    ORD_ASC,
    ORD_DESC
  } order_t;

  // Memory controls from the sequencer
  typedef struct packed {
    logic              sym_we;
    logic [ADDR_W-1:0] sym_waddr;
    logic [SYM_W-1:0]  sym_wdata;
    logic [ADDR_W-1:0] sym_raddr_a;
    logic [ADDR_W-1:0] sym_raddr_b;
    logic              len_we_asc;
    logic              len_we_desc;
    logic [ADDR_W-1:0] len_waddr;
    logic [CNT_W-1:0]  len_wdata;
    logic [ADDR_W-1:0] len_raddr_a;
    logic [ADDR_W-1:0] len_raddr_b;
  } mem_ctl_t;

  // Result hand-off to the output register
  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] pos;
    logic              last;
    logic              trunc;
  } res_t;

endpackage

// File: sv/lyndon_array_both_orders.sv
// ----------------------------------------------------------------------------
// lyndon_array_both_orders
// Lyndon array of a stored string under ascending and descending order.
// ----------------------------------------------------------------------------
// Usage: symbols enter one item per cycle on the in_ channel (tdata = symbol,
// tlast marks the final symbol). Up to 64 symbols are kept; later ones are
// dropped and the result flag tuser goes high for that string. After tlast
// the input channel stalls (in_tready low) while both arrays are built; then
// one result item per position leaves on the out_ channel, position 0 first,
// with tlast on the last position.
// Building is sequential over the symbol and length RAMs: per position and
// order, an init step and a write step, a len[j] read per merge attempt and
// a symbol read per symbol compared, which is quadratic in the string length
// in the worst case. Readout reads each result from the length RAM, then
// loads it into the output register.
// Reset (rst_n low, synchronous) empties the string and returns to loading;
// RAM contents are not cleared. A stalled out_tready holds the result in the
// output register and pauses the readout; no result is lost.
// ----------------------------------------------------------------------------
module lyndon_array_both_orders (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lyn_pkg::IN_SYM_W-1:0]     in_tdata,   // [7:0] symbol
  input  logic                             in_tlast,   // end_of_string
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lyn_pkg::OUT_DATA_W-1:0]   out_tdata,  // [5:0] position,
                                                       // [12:6] lyndon_len_ascending,
                                                       // [19:13] lyndon_len_descending,
                                                       // [23:20] zero
  output logic                             out_tuser,  // truncated
  output logic                             out_tlast   // last_result
);

  import lyn_pkg::*;

  mem_ctl_t         mc;
  res_t             res;
  logic [SYM_W-1:0] sym_rdata_a, sym_rdata_b;
  logic [CNT_W-1:0] lena_rdata_a, lena_rdata_b;
  logic [CNT_W-1:0] lend_rdata_a, lend_rdata_b;
  logic             out_room;

  logic             out_valid_r;
  logic [POS_W-1:0] out_pos_r;
  logic [LEN_W-1:0] out_asc_r, out_desc_r;
  logic             out_trunc_r, out_last_r;

  // sequencer
  lyn_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_last     (in_tlast),
    .in_symbol   (in_tdata),
    .in_ready    (in_tready),
    .mc          (mc),
    .sym_rdata_a (sym_rdata_a),
    .sym_rdata_b (sym_rdata_b),
    .lena_rdata  (lena_rdata_a),
    .lend_rdata  (lend_rdata_a),
    .out_room    (out_room),
    .res         (res)
  );

  // symbol store: two reads per compare step
  lyn_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_sym_ram (
    .clk     (clk),
    .we      (mc.sym_we),
    .waddr   (mc.sym_waddr),
    .wdata   (mc.sym_wdata),
    .raddr_a (mc.sym_raddr_a),
    .raddr_b (mc.sym_raddr_b),
    .rdata_a (sym_rdata_a),
    .rdata_b (sym_rdata_b)
  );

  // ascending lengths: port a for the merge loop, port b for readout
  lyn_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_len_asc_ram (
    .clk     (clk),
    .we      (mc.len_we_asc),
    .waddr   (mc.len_waddr),
    .wdata   (mc.len_wdata),
    .raddr_a (mc.len_raddr_a),
    .raddr_b (mc.len_raddr_b),
    .rdata_a (lena_rdata_a),
    .rdata_b (lena_rdata_b)
  );

  // descending lengths
  lyn_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_len_desc_ram (
    .clk     (clk),
    .we      (mc.len_we_desc),
    .waddr   (mc.len_waddr),
    .wdata   (mc.len_wdata),
    .raddr_a (mc.len_raddr_a),
    .raddr_b (mc.len_raddr_b),
    .rdata_a (lend_rdata_a),
    .rdata_b (lend_rdata_b)
  );

  // output register
  assign out_room = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_pos_r   <= POS_W'(res.pos);
      out_asc_r   <= LEN_W'(lena_rdata_b);
      out_desc_r  <= LEN_W'(lend_rdata_b);
      out_trunc_r <= res.trunc;
      out_last_r  <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - POS_W - 2 * LEN_W)'(0), out_desc_r, out_asc_r, out_pos_r};
  assign out_tuser  = out_trunc_r;
  assign out_tlast  = out_last_r;

endmodule

// File: sv/lyn_ram.sv
// ----------------------------------------------------------------------------
// lyn_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module lyn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: sv/lyn_ctrl.sv
// ----------------------------------------------------------------------------
// lyn_ctrl
// Sequencer: loads the string, runs the right-to-left merge for both symbol
// orders over the RAMs, then walks the positions out.
// ----------------------------------------------------------------------------
module lyn_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  // input items
  input  logic                           in_valid,
  input  logic                           in_last,
  input  logic [lyn_pkg::IN_SYM_W-1:0]   in_symbol,
  output logic                           in_ready,
  // memories
  output lyn_pkg::mem_ctl_t              mc,
  input  logic [lyn_pkg::SYM_W-1:0]      sym_rdata_a,
  input  logic [lyn_pkg::SYM_W-1:0]      sym_rdata_b,
  input  logic [lyn_pkg::CNT_W-1:0]      lena_rdata,
  input  logic [lyn_pkg::CNT_W-1:0]      lend_rdata,
  // results
  input  logic                           out_room,
  output lyn_pkg::res_t                  res
);

  import lyn_pkg::*;

  state_t            state_r, state_nxt;
  order_t            order_r, order_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;   // symbols stored
  logic              ovf_r, ovf_nxt;       // a symbol was dropped
  logic [CNT_W-1:0]  n_r, n_nxt;           // string length being processed
  logic [ADDR_W-1:0] i_r, i_nxt;           // position being built
  logic [CNT_W-1:0]  j_r, j_nxt;           // start of the next word
  logic [CNT_W-1:0]  l_r, l_nxt;           // current length at i
  logic [CNT_W-1:0]  lj_r, lj_nxt;         // length of the word at j
  logic [CNT_W-1:0]  k_r, k_nxt;           // symbols compared so far
  logic [ADDR_W-1:0] pos_r, pos_nxt;       // readout position

  logic              accept;
  logic              room;
  logic [CNT_W-1:0]  addr_p, addr_q, k_inc, n_m1, pos_inc, j_init;
  logic [CNT_W-1:0]  lj_sel;
  logic              prec_xy, prec_yx;

  assign accept  = in_valid && in_ready;
  assign room    = count_r < CNT_W'(MAX_LEN);
  assign addr_p  = CNT_W'(i_r) + k_r;
  assign addr_q  = j_r + k_r;
  assign k_inc   = k_r + CNT_W'(1);
  assign n_m1    = n_r - CNT_W'(1);
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);
  assign j_init  = CNT_W'(i_r) + CNT_W'(1);
  assign lj_sel  = (order_r == ORD_ASC) ? lena_rdata : lend_rdata;

  // symbol order compare
  always_comb begin
    if (order_r == ORD_ASC) begin
      prec_xy = sym_rdata_a < sym_rdata_b;
      prec_yx = sym_rdata_b < sym_rdata_a;
    end else begin
      prec_xy = sym_rdata_a > sym_rdata_b;
      prec_yx = sym_rdata_b > sym_rdata_a;
    end
  end

  // state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      order_r <= ORD_ASC;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      order_r <= order_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    l_r   <= l_nxt;
    lj_r  <= lj_nxt;
    k_r   <= k_nxt;
    pos_r <= pos_nxt;
  end

  // next state and memory controls
  always_comb begin
    state_nxt = state_r;
    order_nxt = order_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    l_nxt     = l_r;
    lj_nxt    = lj_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;

    in_ready = 1'b0;

    mc             = '0;
    mc.sym_waddr   = count_r[ADDR_W-1:0];
    mc.sym_wdata   = in_symbol[SYM_W-1:0];
    mc.sym_raddr_a = addr_p[ADDR_W-1:0];
    mc.sym_raddr_b = addr_q[ADDR_W-1:0];
    mc.len_waddr   = i_r;
    mc.len_wdata   = l_r;
    mc.len_raddr_a = j_r[ADDR_W-1:0];
    mc.len_raddr_b = pos_r;

    res.load  = 1'b0;
    res.pos   = pos_r;
    res.last  = pos_inc == n_r;
    res.trunc = ovf_r;

    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (accept) begin
          if (room) begin
            mc.sym_we = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            // a full store starts the build at the last slot
            n_nxt     = room ? count_r + CNT_W'(1) : count_r;
            i_nxt     = room ? count_r[ADDR_W-1:0] : ADDR_W'(MAX_LEN - 1);
            order_nxt = ORD_ASC;
            state_nxt = ST_INIT;
          end
        end
      end

      ST_INIT: begin
        l_nxt = CNT_W'(1);
        j_nxt = j_init;
        state_nxt = (j_init >= n_r) ? ST_WRITE : ST_LREQ;
      end

      ST_LREQ: begin
        state_nxt = ST_LDAT;
      end

      ST_LDAT: begin
        lj_nxt    = lj_sel;
        k_nxt     = '0;
        state_nxt = ST_CREQ;
      end

      ST_CREQ: begin
        state_nxt = ST_CDAT;
      end

      ST_CDAT: begin
        priority if (prec_xy) begin
          l_nxt     = l_r + lj_r;
          j_nxt     = j_r + lj_r;
          state_nxt = (j_r + lj_r >= n_r) ? ST_WRITE : ST_LREQ;
        end else if (prec_yx) begin
          state_nxt = ST_WRITE;
        end else if (k_inc == l_r || k_inc == lj_r) begin
          // one word ran out: merge only if the left word is a proper prefix
          if (k_inc == l_r && k_inc < lj_r) begin
            l_nxt     = l_r + lj_r;
            j_nxt     = j_r + lj_r;
            state_nxt = (j_r + lj_r >= n_r) ? ST_WRITE : ST_LREQ;
          end else begin
            state_nxt = ST_WRITE;
          end
        end else begin
          k_nxt     = k_inc;
          state_nxt = ST_CREQ;
        end
      end

      ST_WRITE: begin
        mc.len_we_asc  = order_r == ORD_ASC;
        mc.len_we_desc = order_r == ORD_DESC;
        if (i_r == '0) begin
          if (order_r == ORD_ASC) begin
            order_nxt = ORD_DESC;
            i_nxt     = n_m1[ADDR_W-1:0];
            state_nxt = ST_INIT;
          end else begin
            pos_nxt   = '0;
            state_nxt = ST_OREQ;
          end
        end else begin
          i_nxt     = i_r - ADDR_W'(1);
          state_nxt = ST_INIT;
        end
      end

      ST_OREQ: begin
        state_nxt = ST_OLOAD;
      end

      ST_OLOAD: begin
        if (out_room) begin
          res.load = 1'b1;
          if (pos_inc == n_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            pos_nxt   = pos_r + ADDR_W'(1);
            state_nxt = ST_OREQ;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // a computed length lies inside the string
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (l_r != '0 && CNT_W'(i_r) + l_r <= n_r))
    else $error("length at position runs past the string end");

  // symbol reads stay inside the stored string
  a_sym_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CREQ) |-> (addr_q < n_r && k_r < l_r && k_r < lj_r))
    else $error("symbol read outside the string");

  // a result is handed over only when the output register can take it
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> out_room)
    else $error("result loaded into a full output register");

  // after the final result the loader starts empty
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (res.load && res.last) |=> (count_r == '0 && !ovf_r && state_r == ST_LOAD))
    else $error("string state not cleared after final result");

endmodule

// File: tb/tb_lyndon_array_both_orders.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lyndon_array_both_orders
// Streaming testbench for the two-order Lyndon array engine.
// ----------------------------------------------------------------------------
// A queue of symbol items (strings closed by tlast) is filled up front and
// fed by a bursty driver. On each accepted final symbol the testbench
// computes the Lyndon arrays of the stored string under ascending and
// descending order and queues one expected result item per position. A
// monitor checks every result item field by field against the oldest one,
// while the receiver stalls in changing patterns. Strings cover single
// symbols, equal runs, prefix cases, full capacity and overflow.
// ----------------------------------------------------------------------------
module tb_lyndon_array_both_orders;
  import lyn_pkg::*;

  localparam int IDLE_LIMIT = 200000;  // cycles with no item moving
  localparam int TAIL_CYCLES = 200;
  localparam int ITEM_TARGET = 460;

  typedef enum int {
    RX_FREE,    // always ready
    RX_LIGHT,   // ready most cycles
    RX_HEAVY,   // ready few cycles
    RX_BURSTY   // ready, with long stall runs
  } rx_mode_t;

  typedef enum int {
    ALPHA_FULL,     // any 8-bit symbol
    ALPHA_EXTREME,  // only 0 and 255
    ALPHA_SMALL     // 0..3, many repeats
  } alpha_t;

  typedef struct {
    logic [IN_SYM_W-1:0] sym;
    logic                last;
    bit                  wait_drain;  // hold off until all results are in
  } sym_item_t;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [LEN_W-1:0] len_asc;
    logic [LEN_W-1:0] len_desc;
    logic             trunc;
    logic             last;
  } lyn_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_SYM_W-1:0]   in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  sym_item_t   sym_pending_q[$];
  lyn_result_t len_result_q[$];

  // predictor state: the string being collected
  logic [SYM_W-1:0] str_buf[MAX_LEN];
  int unsigned      str_cnt = 0;
  bit               str_ovf = 1'b0;
  int unsigned      lyn_len[MAX_LEN];
  int unsigned      asc_len[MAX_LEN];

  int unsigned want_total = 0;  // results predicted so far
  int unsigned got_total = 0;   // results received so far
  int          mismatches = 0;
  int unsigned idle_cycles = 0;

  lyndon_array_both_orders dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit sym_precedes(order_t ord, logic [SYM_W-1:0] x,
                                      logic [SYM_W-1:0] y);
    return (ord == ORD_ASC) ? (x < y) : (x > y);
  endfunction

  // Lyndon array of str_buf[0..str_cnt-1] into lyn_len, built right to left.
  // The word at i absorbs its right neighbor while it is strictly smaller;
  // a proper prefix is smaller, equal words stay apart.
  function automatic void lyndon_lengths(order_t ord);
    int unsigned i, j, p, q, pe, qe;
    bit smaller, decided;
    for (int k = str_cnt; k > 0; k--) begin
      i = k - 1;
      j = i + 1;
      lyn_len[i] = 1;
      while (j < str_cnt) begin
        p = i;
        pe = j - 1;
        q = j;
        qe = j + lyn_len[j] - 1;
        smaller = 1'b0;
        decided = 1'b0;
        while (!decided && p <= pe && q <= qe) begin
          if (sym_precedes(ord, str_buf[p], str_buf[q])) begin
            smaller = 1'b1;
            decided = 1'b1;
          end else if (sym_precedes(ord, str_buf[q], str_buf[p])) begin
            decided = 1'b1;
          end else begin
            p++;
            q++;
          end
        end
        if (!decided) smaller = (q <= qe);
        if (!smaller) break;
        lyn_len[i] += lyn_len[j];
        j += lyn_len[j];
      end
    end
  endfunction

  task automatic queue_item(logic [IN_SYM_W-1:0] sym, logic last, bit drain);
    sym_item_t it;
    it.sym = sym;
    it.last = last;
    it.wait_drain = drain;
    sym_pending_q.push_back(it);
  endtask

  task automatic queue_string(int unsigned len, alpha_t alpha, bit drain);
    logic [IN_SYM_W-1:0] sym;
    for (int unsigned k = 0; k < len; k++) begin
      case (alpha)
        ALPHA_EXTREME: sym = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        ALPHA_SMALL:   sym = IN_SYM_W'($urandom_range(0, 3));
        default:       sym = IN_SYM_W'($urandom_range(0, 255));
      endcase
      queue_item(sym, k == len - 1, drain && k == 0);
    end
  endtask

  // Driver: bursts with gaps; predicts on every accepted item
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    sym_item_t   cur;
    lyn_result_t res;
    bit          present;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        cur = sym_pending_q.pop_front();
        if (str_cnt < MAX_LEN) begin
          str_buf[str_cnt] = cur.sym[SYM_W-1:0];
          str_cnt++;
        end else begin
          str_ovf = 1'b1;
        end
        // final symbol: both arrays, one result per stored position
        if (cur.last) begin
          lyndon_lengths(ORD_ASC);
          for (int unsigned i = 0; i < str_cnt; i++) asc_len[i] = lyn_len[i];
          lyndon_lengths(ORD_DESC);
          for (int unsigned i = 0; i < str_cnt; i++) begin
            res.pos = POS_W'(i);
            res.len_asc = LEN_W'(asc_len[i]);
            res.len_desc = LEN_W'(lyn_len[i]);
            res.trunc = str_ovf;
            res.last = (i == str_cnt - 1);
            len_result_q.push_back(res);
          end
          want_total += str_cnt;
          str_cnt = 0;
          str_ovf = 1'b0;
        end
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      // a presented item stays until taken
      if (!(in_tvalid && !in_tready)) begin
        present = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (sym_pending_q.size() > 0 &&
                     (!sym_pending_q[0].wait_drain || want_total == got_total)) begin
          present = 1'b1;
        end
        in_tvalid <= present;
        if (present) begin
          in_tdata <= sym_pending_q[0].sym;
          in_tlast <= sym_pending_q[0].last;
        end
      end
    end
  end

  // Receiver: stall pattern changes from phase to phase
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned rx_phase_left = 0;
  int unsigned rx_stall_left = 0;

  always @(posedge clk) begin
    logic rdy;
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(50, 300);
    end else begin
      rx_phase_left--;
    end
    case (rx_mode)
      RX_FREE:  rdy = 1'b1;
      RX_LIGHT: rdy = ($urandom_range(0, 3) != 0);
      RX_HEAVY: rdy = ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_stall_left > 0) begin
          rdy = 1'b0;
          rx_stall_left--;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) rx_stall_left = $urandom_range(5, 40);
        end
      end
    endcase
    out_tready <= rdy;
  end

  // Monitor: compare each result item with the oldest prediction
  always @(posedge clk) begin
    lyn_result_t want;
    if (!rst_n) begin
      got_total <= 0;
    end else if (out_tvalid && out_tready) begin
      got_total <= got_total + 1;
      if (len_result_q.size() == 0) begin
        $error("unexpected result item: tdata=%h tuser=%b tlast=%b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = len_result_q.pop_front();
        if (out_tdata[POS_W-1:0] !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, out_tdata[POS_W-1:0]);
          mismatches++;
        end
        if (out_tdata[POS_W +: LEN_W] !== want.len_asc) begin
          $error("lyndon_len_ascending: expected %0d, got %0d",
                 want.len_asc, out_tdata[POS_W +: LEN_W]);
          mismatches++;
        end
        if (out_tdata[POS_W+LEN_W +: LEN_W] !== want.len_desc) begin
          $error("lyndon_len_descending: expected %0d, got %0d",
                 want.len_desc, out_tdata[POS_W+LEN_W +: LEN_W]);
          mismatches++;
        end
        if (out_tdata[OUT_DATA_W-1:POS_W+2*LEN_W] !== '0) begin
          $error("tdata pad: expected 0, got %h", out_tdata[OUT_DATA_W-1:POS_W+2*LEN_W]);
          mismatches++;
        end
        if (out_tuser !== want.trunc) begin
          $error("truncated: expected %b, got %b", want.trunc, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: nothing moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_lyndon_array_both_orders: errors");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned str_idx;
    int unsigned kind;
    int unsigned len;
    alpha_t      alpha;

    // single symbols at both extremes
    queue_item(8'h00, 1'b1, 1'b1);
    queue_item(8'hFF, 1'b1, 1'b0);
    // rising and falling pair: merges under one order only
    queue_item(8'h00, 1'b0, 1'b0);
    queue_item(8'hFF, 1'b1, 1'b0);
    queue_item(8'hFF, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);
    // equal symbols never merge
    queue_item(8'h07, 1'b0, 1'b0);
    queue_item(8'h07, 1'b0, 1'b0);
    queue_item(8'h07, 1'b1, 1'b0);
    // repeated word: proper prefix decides
    queue_item(8'h01, 1'b0, 1'b0);
    queue_item(8'h02, 1'b0, 1'b0);
    queue_item(8'h01, 1'b0, 1'b0);
    queue_item(8'h02, 1'b1, 1'b0);
    // alternating bit patterns
    queue_item(8'h55, 1'b0, 1'b1);
    queue_item(8'hAA, 1'b0, 1'b0);
    queue_item(8'h55, 1'b0, 1'b0);
    queue_item(8'hAA, 1'b0, 1'b0);
    queue_item(8'h00, 1'b1, 1'b0);

    // random strings: mostly short, a few full and overflowing ones
    str_idx = 0;
    while (sym_pending_q.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      alpha = alpha_t'($urandom_range(0, 2));
      if (str_idx == 0) begin
        len = MAX_LEN;
        alpha = ALPHA_FULL;
      end else if (str_idx == 1) begin
        len = MAX_LEN + 3;
        alpha = ALPHA_SMALL;
      end else if (kind < 78) begin
        len = $urandom_range(1, 10);
      end else if (kind < 90) begin
        len = $urandom_range(11, 30);
      end else if (kind < 95) begin
        len = MAX_LEN;
      end else begin
        len = $urandom_range(MAX_LEN + 1, MAX_LEN + 6);
      end
      queue_string(len, alpha, str_idx == 2 || $urandom_range(0, 15) == 0);
      str_idx++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (sym_pending_q.size() != 0 || in_tvalid) @(negedge clk);
    while (want_total != got_total) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0 && len_result_q.size() == 0) begin
      $display("tb_lyndon_array_both_orders: clean");
    end else begin
      $display("tb_lyndon_array_both_orders: errors");
    end
    $finish;
  end

endmodule

// File: files.f
sv/lyn_pkg.sv
sv/lyn_ram.sv
sv/lyn_ctrl.sv
sv/lyndon_array_both_orders.sv
tb/tb_lyndon_array_both_orders.sv
